>>> src/lsd_radix_sort_byte_keys_defines.svh
// Assertion macros shared by the radix sorter RTL.
// Depends on nothing; files that assert include it inside a module body.
`ifndef LSD_RADIX_SORT_BYTE_KEYS_DEFINES_SVH
`define LSD_RADIX_SORT_BYTE_KEYS_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define LSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/lsd_pkg.sv
// Package for the radix sorter: default sizes, digit constants, sequencer states.
// Depends on nothing.
`timescale 1ns / 1ps
package lsd_pkg;

  localparam int DEF_MAX_ITEMS     = 64;
  localparam int DEF_KEY_BYTES     = 6;
  localparam int DEF_PAYLOAD_WIDTH = 32;
  localparam int DIGIT_W           = 8;
  localparam int DIGIT_VALUES      = 256;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLR,
    ST_CNT_A,
    ST_CNT_B,
    ST_CNT_C,
    ST_PFX_A,
    ST_PFX_B,
    ST_SCT_A,
    ST_SCT_B,
    ST_SCT_C,
    ST_OUT_A,
    ST_OUT_B,
    ST_OUT_C
  } state_t;

endpackage

>>> src/lsd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
`timescale 1ns / 1ps
module lsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/lsd_radix_sort_byte_keys.sv
// Top level of the LSD radix sorter for records with byte-wise keys.
// Depends on lsd_pkg, lsd_ram and lsd_radix_sort_byte_keys_defines.svh.
//
//   Channel | Ports       | Direction | Contents
//   input   | in_t*       | slave     | tdata = key, payload; tlast = last
//   output  | out_t*      | master    | tdata = key_res, payload_res; tlast = last_res;
//           |             |           | tuser = overflow
//
// Words are loaded one per cycle while in_tready is high. The word with tlast starts
// the sort, which makes KEY_BYTES passes over the n stored records: every pass clears
// the 256-entry count memory, counts, forms prefix sums and scatters, the last three
// steps each a read-modify-write of the count memory through one shared sum
// (increment, add or decrement). Output offers one word at a time and fetches the
// next only after the last was taken. in_tready is low after the tlast word until the
// last sorted word has been taken. Reset (rst_n low, synchronous) empties the record set.
`timescale 1ns / 1ps
module lsd_radix_sort_byte_keys #(
  parameter int MAX_ITEMS     = lsd_pkg::DEF_MAX_ITEMS,
  parameter int KEY_BYTES     = lsd_pkg::DEF_KEY_BYTES,
  parameter int PAYLOAD_WIDTH = lsd_pkg::DEF_PAYLOAD_WIDTH,
  parameter int TDW = ((8 * KEY_BYTES + PAYLOAD_WIDTH + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [TDW-1:0] in_tdata,   // key, payload, zero padding (lowest bit up)
  input  logic           in_tlast,   // last
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [TDW-1:0] out_tdata,  // key_res, payload_res, zero padding
  output logic           out_tlast,  // last_res
  output logic           out_tuser   // overflow
);

  import lsd_pkg::*;

  `include "lsd_radix_sort_byte_keys_defines.svh"

  localparam int KW  = 8 * KEY_BYTES;
  localparam int RW  = KW + PAYLOAD_WIDTH;
  localparam int AW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CIW = $clog2(MAX_ITEMS + 1);
  localparam int PSW = $clog2(KEY_BYTES + 1);
  localparam logic [CIW-1:0] MAXC = CIW'(MAX_ITEMS);
  localparam logic [PSW-1:0] LASTPASS = PSW'(KEY_BYTES - 1);
  localparam logic [DIGIT_W-1:0] DIG_TOP = DIGIT_W'(DIGIT_VALUES - 1);

  state_t               state_r, state_nxt;
  logic [PSW-1:0]       pass_r, pass_nxt;
  logic [CIW-1:0]       idx_r, idx_nxt;
  logic [CIW-1:0]       n_r, n_nxt;
  logic [CIW-1:0]       items_r, items_nxt;
  logic                 drop_r, drop_nxt;
  logic [DIGIT_W-1:0]   dig_r, dig_nxt;    // count memory sweep address
  logic [DIGIT_W-1:0]   digv_r, digv_nxt;  // digit of the record in flight
  logic [CIW-1:0]       acc_r, acc_nxt;
  logic [RW-1:0]        rec_r, rec_nxt;
  logic [RW-1:0]        out_rec_r, out_rec_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  // Record buffers: buffer 0 is loaded, passes ping-pong between the two.
  logic [AW-1:0] rd_addr, wr_addr;
  logic [RW-1:0] wr_data, rd0, rd1, rd_data;
  logic          we0, we1;

  // Count memory.
  logic               cnt_we;
  logic [DIGIT_W-1:0] cnt_waddr, cnt_raddr;
  logic [CIW-1:0]     cnt_wdata, cnt_rdata;

  logic [DIGIT_W-1:0] rd_digit;
  logic [CIW-1:0]     cnt_sum;

  lsd_ram #(.WIDTH(RW), .DEPTH(MAX_ITEMS)) u_buf0 (
    .clk(clk), .we(we0), .waddr(wr_addr), .wdata(wr_data), .raddr(rd_addr), .rdata(rd0)
  );

  lsd_ram #(.WIDTH(RW), .DEPTH(MAX_ITEMS)) u_buf1 (
    .clk(clk), .we(we1), .waddr(wr_addr), .wdata(wr_data), .raddr(rd_addr), .rdata(rd1)
  );

  lsd_ram #(.WIDTH(CIW), .DEPTH(DIGIT_VALUES)) u_counts (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  // The source of the current pass, and the sorted set after the last pass,
  // sits in the buffer chosen by the low bit of the pass number.
  assign rd_data  = pass_r[0] ? rd1 : rd0;
  assign rd_digit = rd_data[pass_r * DIGIT_W +: DIGIT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      items_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      items_r <= items_nxt;
      drop_r  <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pass_r     <= pass_nxt;
    idx_r      <= idx_nxt;
    n_r        <= n_nxt;
    dig_r      <= dig_nxt;
    digv_r     <= digv_nxt;
    acc_r      <= acc_nxt;
    rec_r      <= rec_nxt;
    out_rec_r  <= out_rec_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    pass_nxt     = pass_r;
    idx_nxt      = idx_r;
    n_nxt        = n_r;
    items_nxt    = items_r;
    drop_nxt     = drop_r;
    dig_nxt      = dig_r;
    digv_nxt     = digv_r;
    acc_nxt      = acc_r;
    rec_nxt      = rec_r;
    out_rec_nxt  = out_rec_r;
    out_last_nxt = out_last_r;
    out_ovf_nxt  = out_ovf_r;

    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    rd_addr    = idx_r[AW-1:0];
    wr_addr    = items_r[AW-1:0];
    wr_data    = in_tdata[RW-1:0];
    we0        = 1'b0;
    we1        = 1'b0;
    cnt_we     = 1'b0;
    cnt_waddr  = dig_r;
    cnt_wdata  = '0;
    cnt_raddr  = dig_r;
    cnt_sum    = '0;

    case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (items_r != MAXC) begin
            we0       = 1'b1;
            items_nxt = items_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_tlast) begin
            n_nxt     = items_nxt;
            pass_nxt  = '0;
            dig_nxt   = '0;
            state_nxt = ST_CLR;
          end
        end
      end
      ST_CLR: begin
        cnt_we  = 1'b1;
        dig_nxt = dig_r + 1'b1;
        if (dig_r == DIG_TOP) begin
          idx_nxt   = '0;
          state_nxt = ST_CNT_A;
        end
      end
      ST_CNT_A: begin
        state_nxt = ST_CNT_B;
      end
      ST_CNT_B: begin
        cnt_raddr = rd_digit;
        digv_nxt  = rd_digit;
        state_nxt = ST_CNT_C;
      end
      ST_CNT_C: begin
        cnt_sum   = cnt_rdata + 1'b1;
        cnt_we    = 1'b1;
        cnt_waddr = digv_r;
        cnt_wdata = cnt_sum;
        idx_nxt   = idx_r + 1'b1;
        if (idx_nxt == n_r) begin
          dig_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = ST_PFX_A;
        end else begin
          state_nxt = ST_CNT_A;
        end
      end
      ST_PFX_A: begin
        state_nxt = ST_PFX_B;
      end
      ST_PFX_B: begin
        cnt_sum   = acc_r + cnt_rdata;
        cnt_we    = 1'b1;
        cnt_wdata = cnt_sum;
        acc_nxt   = cnt_sum;
        dig_nxt   = dig_r + 1'b1;
        if (dig_r == DIG_TOP) begin
          idx_nxt   = n_r - 1'b1;
          state_nxt = ST_SCT_A;
        end else begin
          state_nxt = ST_PFX_A;
        end
      end
      ST_SCT_A: begin
        state_nxt = ST_SCT_B;
      end
      ST_SCT_B: begin
        rec_nxt   = rd_data;
        cnt_raddr = rd_digit;
        digv_nxt  = rd_digit;
        state_nxt = ST_SCT_C;
      end
      ST_SCT_C: begin
        // Inclusive prefix sums: the slot is the decremented count.
        cnt_sum   = cnt_rdata - 1'b1;
        cnt_we    = 1'b1;
        cnt_waddr = digv_r;
        cnt_wdata = cnt_sum;
        wr_addr   = cnt_sum[AW-1:0];
        wr_data   = rec_r;
        we0       = pass_r[0];
        we1       = ~pass_r[0];
        if (idx_r == '0) begin
          pass_nxt = pass_r + 1'b1;
          if (pass_r == LASTPASS) begin
            state_nxt = ST_OUT_A;
          end else begin
            dig_nxt   = '0;
            state_nxt = ST_CLR;
          end
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = ST_SCT_A;
        end
      end
      ST_OUT_A: begin
        state_nxt = ST_OUT_B;
      end
      ST_OUT_B: begin
        out_rec_nxt  = rd_data;
        out_last_nxt = (idx_r + 1'b1) == n_r;
        out_ovf_nxt  = drop_r;
        state_nxt    = ST_OUT_C;
      end
      ST_OUT_C: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (out_last_r) begin
            items_nxt = '0;
            drop_nxt  = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_OUT_A;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  assign out_tdata = TDW'(out_rec_r);
  assign out_tlast = out_last_r;
  assign out_tuser = out_ovf_r;

  // The block never loads while a sorted word is on offer.
  `LSD_ASSERT_NOW(a_no_load_while_out, out_tvalid, !in_tready, "load during output")
  // The stored record count never exceeds the capacity.
  `LSD_ASSERT_NOW(a_items_cap, 1'b1, items_r <= MAXC, "item count above capacity")
  // A scatter always finds a nonzero count for its digit.
  `LSD_ASSERT_NOW(a_scatter_count, state_r == ST_SCT_C, cnt_rdata != '0, "empty bucket")
  // Taking the final sorted word reopens the input.
  `LSD_ASSERT_NEXT(a_reopen, out_tvalid && out_tready && out_tlast, in_tready,
                   "input not reopened")

endmodule
